// ===== hw/rtl/tscs_pkg.sv =====
// Shared constants, types and codes for the text screen cursor/scroll core.
`default_nettype none
package tscs_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS_USED = 24;
  localparam int SCREEN    = COLUMNS * ROWS_USED;
  localparam int MOVE      = SCREEN - COLUMNS;
  localparam int AW        = $clog2(SCREEN);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS_USED + 1);
  localparam int POS_W     = 11;
  localparam int CODE_W    = 9;
  localparam int CELL_W    = 16;

  typedef logic [AW-1:0]     addr_t;
  typedef logic [CW-1:0]     col_t;
  typedef logic [RW-1:0]     row_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CELL_W-1:0] cell_t;

  localparam cell_t ATTR_NORMAL    = 16'h0700;
  localparam cell_t CELL_BLANK     = 16'h0720;
  localparam code_t CODE_NEWLINE   = 9'd10;
  localparam code_t CODE_BACKSPACE = 9'h100;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    cell_t wr_data;
    logic  scroll;
  } put_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tscs_ram.sv =====
// Screen cell store: one write port, one registered read port.
`default_nettype none
module tscs_ram (
  input  wire                  clk,
  input  wire                  we,
  input  wire tscs_pkg::addr_t waddr,
  input  wire tscs_pkg::cell_t wdata,
  input  wire tscs_pkg::addr_t raddr,
  output tscs_pkg::cell_t      rdata
);

  tscs_pkg::cell_t mem [tscs_pkg::SCREEN];
  tscs_pkg::cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tscs_cursor.sv =====
// Cursor position tracking and put-time cell write decode.
`default_nettype none
module tscs_cursor (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  wire tscs_pkg::code_t code,
  output tscs_pkg::put_t       put,
  output tscs_pkg::addr_t      cur
);

  tscs_pkg::addr_t cur_r, cur_nxt;
  tscs_pkg::col_t  col_r, col_nxt;
  tscs_pkg::row_t  row_r, row_nxt;
  logic            is_nl;
  logic            is_bs;

  always_comb begin
    is_nl   = (code == tscs_pkg::CODE_NEWLINE);
    is_bs   = (code == tscs_pkg::CODE_BACKSPACE);
    cur_nxt = cur_r;
    col_nxt = col_r;
    row_nxt = row_r;
    put     = '0;
    if (is_nl) begin
      col_nxt = '0;
      row_nxt = row_r + tscs_pkg::row_t'(1);
      cur_nxt = cur_r + tscs_pkg::addr_t'(tscs_pkg::COLUMNS) - tscs_pkg::addr_t'(col_r);
    end else if (is_bs) begin
      if (cur_r != '0) begin
        cur_nxt = cur_r - tscs_pkg::addr_t'(1);
        if (col_r == '0) begin
          col_nxt = tscs_pkg::col_t'(tscs_pkg::COLUMNS - 1);
          row_nxt = row_r - tscs_pkg::row_t'(1);
        end else begin
          col_nxt = col_r - tscs_pkg::col_t'(1);
        end
      end
      put.wr_en   = 1'b1;
      put.wr_addr = cur_nxt;
      put.wr_data = tscs_pkg::CELL_BLANK;
    end else begin
      put.wr_en   = 1'b1;
      put.wr_addr = cur_r;
      put.wr_data = tscs_pkg::ATTR_NORMAL | tscs_pkg::cell_t'(code[7:0]);
      cur_nxt     = cur_r + tscs_pkg::addr_t'(1);
      if (col_r == tscs_pkg::col_t'(tscs_pkg::COLUMNS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + tscs_pkg::row_t'(1);
      end else begin
        col_nxt = col_r + tscs_pkg::col_t'(1);
      end
    end
    put.scroll = (row_nxt == tscs_pkg::row_t'(tscs_pkg::ROWS_USED));
    if (put.scroll) begin
      row_nxt = tscs_pkg::row_t'(tscs_pkg::ROWS_USED - 1);
      col_nxt = '0;
      cur_nxt = tscs_pkg::addr_t'(tscs_pkg::MOVE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      cur_r <= cur_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign cur = cur_r;

endmodule
`default_nettype wire

// ===== hw/rtl/text_screen_cursor_scroll_core.sv =====
// Top level: command sequencer, scroll/clear sweep and result registers.
//
// One item at a time: start is taken when busy is low. A put returns its result
// in the cycle after the transfer; a read goes through the registered store read
// port and then the result register. A put that moves the cursor past the last
// used row scrolls the screen with one pass over the store, one cell per cycle.
// After reset the store is cleared by the same pass while busy is high. Results
// are strobed on out_valid for exactly one cycle and cannot be held off. Cell
// indexes at or beyond SCREEN (past the last used row) read as 0.
`default_nettype none
module text_screen_cursor_scroll_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_operation,
  input  wire  [8:0]  in_char_code,
  input  wire  [10:0] in_cell_index,
  output logic        out_valid,
  output logic [10:0] out_cursor_pos,
  output logic [15:0] out_cell_data,
  output logic        out_scrolled
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;

  logic [2:0]      state_r, state_nxt;
  tscs_pkg::addr_t cnt_r, cnt_nxt;
  logic            clr_r, clr_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            pw_valid_r;
  tscs_pkg::addr_t pw_addr_r;
  logic            pw_zero_r;
  logic            out_valid_r, out_valid_nxt;
  tscs_pkg::cell_t out_data_r, out_data_nxt;
  logic            out_scr_r, out_scr_nxt;

  logic            accept;
  logic            put_step;
  tscs_pkg::put_t  put;
  tscs_pkg::addr_t cur;
  logic            ram_we;
  tscs_pkg::addr_t ram_waddr;
  tscs_pkg::cell_t ram_wdata;
  tscs_pkg::addr_t ram_raddr;
  tscs_pkg::cell_t ram_rdata;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign put_step = accept && (in_operation == tscs_pkg::OP_PUT);

  tscs_cursor u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (put_step),
    .code  (in_char_code),
    .put   (put),
    .cur   (cur)
  );

  always_comb begin
    if (pw_valid_r) begin
      ram_we    = 1'b1;
      ram_waddr = pw_addr_r;
      ram_wdata = pw_zero_r ? '0 : ram_rdata;
    end else begin
      ram_we    = put_step && put.wr_en;
      ram_waddr = put.wr_addr;
      ram_wdata = put.wr_data;
    end
    if (state_r == S_SWEEP) begin
      ram_raddr = (int'(cnt_r) < tscs_pkg::MOVE) ?
                  tscs_pkg::addr_t'(int'(cnt_r) + tscs_pkg::COLUMNS) : '0;
    end else begin
      ram_raddr = tscs_pkg::addr_t'(in_cell_index);
    end
  end

  tscs_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    out_scr_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == tscs_pkg::OP_READ) begin
            rd_ok_nxt = (int'(in_cell_index) < tscs_pkg::SCREEN);
            state_nxt = S_RD;
          end else if (put.scroll) begin
            cnt_nxt   = '0;
            clr_nxt   = 1'b0;
            state_nxt = S_SWEEP;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_ok_r ? ram_rdata : '0;
        state_nxt     = S_IDLE;
      end
      S_SWEEP: begin
        cnt_nxt = cnt_r + tscs_pkg::addr_t'(1);
        if (cnt_r == tscs_pkg::addr_t'(tscs_pkg::SCREEN - 1)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        out_valid_nxt = !clr_r;
        out_scr_nxt   = !clr_r;
        clr_nxt       = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      cnt_r       <= '0;
      clr_r       <= 1'b1;
      pw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      pw_valid_r  <= (state_r == S_SWEEP);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r    <= rd_ok_nxt;
    pw_addr_r  <= cnt_r;
    pw_zero_r  <= clr_r || (int'(cnt_r) >= tscs_pkg::MOVE);
    out_data_r <= out_data_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_data  = out_data_r;
  assign out_scrolled   = out_scr_r;
  assign out_cursor_pos = tscs_pkg::pos_t'(cur);

  a_sweep_no_put_write: assert property (@(posedge clk) disable iff (!rst_n)
    pw_valid_r |-> !accept)
    else $error("sweep write overlaps a put transfer");

  a_put_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    (put_step && !put.scroll) |=> (out_valid && !out_scrolled))
    else $error("put result not strobed on the next cycle");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |-> (int'(cur) == tscs_pkg::MOVE))
    else $error("cursor not on the last used row after a scroll");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cur) < tscs_pkg::SCREEN)
    else $error("cursor beyond the used rows");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !out_valid)
    else $error("result strobed during the clearing pass");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the text screen core: directed and random put/read traffic.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tscs_pkg::*;

  localparam int DEPTH       = SCREEN + COLUMNS;
  localparam int IDLE_LIMIT  = 8000;
  localparam int TAIL_CYCLES = 2000;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    pos_t  cursor;
    cell_t data;
    logic  scrolled;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [8:0]  in_char_code;
  logic [10:0] in_cell_index;
  logic        out_valid;
  logic [10:0] out_cursor_pos;
  logic [15:0] out_cell_data;
  logic        out_scrolled;

  cell_t           shadow_cells [DEPTH];
  int unsigned     shadow_cursor;
  console_result_t pending_results [$];
  int              errors;
  int              items_sent;
  int              gap_limit;
  int              idle_cycles;

  text_screen_cursor_scroll_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic console_result_t predict_console(input logic op, input code_t code,
                                                      input logic [10:0] idx);
    console_result_t r;
    int unsigned     p;
    r = '0;
    if (op == OP_PUT) begin
      p = shadow_cursor;
      if (code == CODE_NEWLINE) begin
        p = p + COLUMNS - (p % COLUMNS);
      end else if (code == CODE_BACKSPACE) begin
        if (p > 0) p--;
      end else begin
        shadow_cells[p] = ATTR_NORMAL | cell_t'(code[7:0]);
        p++;
      end
      if (p / COLUMNS >= ROWS_USED) begin
        for (int i = 0; i < MOVE; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
        p -= COLUMNS;
        for (int i = p; i < SCREEN; i++) shadow_cells[i] = '0;
        r.scrolled = 1'b1;
      end
      shadow_cursor = p;
      if (code == CODE_BACKSPACE) shadow_cells[p] = CELL_BLANK;
    end else if (idx < DEPTH) begin
      r.data = shadow_cells[idx];
    end
    r.cursor = pos_t'(shadow_cursor);
    return r;
  endfunction

  task automatic send_item(input logic op, input code_t code, input logic [10:0] idx);
    int gap;
    gap = (gap_limit > 0) ? $urandom_range(0, gap_limit) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_operation  <= op;
    in_char_code  <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_console(op, code, idx));
    items_sent++;
  endtask

  task automatic put_char(input code_t code);
    send_item(OP_PUT, code, 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [10:0] idx);
    send_item(OP_READ, code_t'($urandom_range(0, 511)), idx);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    console_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cursor %0d data %h scrolled %b",
                 $time, out_cursor_pos, out_cell_data, out_scrolled);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_cursor_pos !== exp_r.cursor) begin
          $display("%0t: cursor_pos expected %0d actual %0d", $time, exp_r.cursor,
                   out_cursor_pos);
          errors++;
        end
        if (out_cell_data !== exp_r.data) begin
          $display("%0t: cell_data expected %h actual %h", $time, exp_r.data, out_cell_data);
          errors++;
        end
        if (out_scrolled !== exp_r.scrolled) begin
          $display("%0t: scrolled expected %b actual %b", $time, exp_r.scrolled,
                   out_scrolled);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic test_control_codes();
    gap_limit = 10;
    put_char(CODE_BACKSPACE);
    read_cell(11'd0);
    put_char(9'h041);
    put_char(9'h000);
    put_char(9'h0ff);
    put_char(9'h101);
    put_char(9'h1ff);
    put_char(CODE_BACKSPACE);
    put_char(CODE_NEWLINE);
    for (int i = 0; i < 5; i++) read_cell(11'(i));
    wait_drained();
  endtask

  task automatic test_read_range();
    gap_limit = 0;
    read_cell(11'(SCREEN - 1));
    read_cell(11'(SCREEN));
    read_cell(11'(DEPTH - 1));
    read_cell(11'(DEPTH));
    read_cell(11'h7ff);
    wait_drained();
  endtask

  task automatic test_scroll();
    gap_limit = 3;
    while (shadow_cursor < MOVE) put_char(CODE_NEWLINE);
    put_char(9'h05a);
    put_char(CODE_NEWLINE);
    read_cell(11'(MOVE - COLUMNS));
    read_cell(11'(MOVE));
    read_cell(11'd0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int line_len;
    int roll;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 10;
      line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(20, 120);
      for (int k = 0; k < line_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12)
          read_cell(11'($urandom_range(0, SCREEN - 1)));
        else if (roll < 16)
          read_cell(11'($urandom_range(MOVE - COLUMNS, DEPTH - 1)));
        else if (roll < 20)
          read_cell(11'($urandom_range(0, 2047)));
        else if (roll < 25)
          put_char(CODE_BACKSPACE);
        else if (roll < 30)
          put_char(code_t'($urandom_range(257, 511)));
        else
          put_char(code_t'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) != 0) put_char(CODE_NEWLINE);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = OP_PUT;
    in_char_code  = '0;
    in_cell_index = '0;
    errors        = 0;
    items_sent    = 0;
    gap_limit     = 0;
    idle_cycles   = 0;
    shadow_cursor = 0;
    for (int i = 0; i < DEPTH; i++) shadow_cells[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_control_codes();
    test_read_range();
    test_scroll();
    test_random_traffic();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
